>>> hw/rtl/das_pkg.sv
`timescale 1ns / 1ps
package das_pkg;

   localparam int DIR_MAX    = 16383;
   localparam int DIR_BITS   = 15;
   localparam int SQRT_STEPS = 17;

   localparam logic [4:0] TERM_XYZ_LAST = 5'd20;
   localparam logic [4:0] TERM_AY_FIRST = 5'd21;
   localparam logic [4:0] TERM_AY_LAST  = 5'd22;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_MAC_MUL,
      ST_MAC_ACC,
      ST_CHECK,
      ST_SQRT,
      ST_NORM,
      ST_CORDIC,
      ST_FIN_ANGLE,
      ST_FIN_ROUND,
      ST_WRITE
   } das_state_type;

   typedef struct packed {
      logic       load;
      logic       win_wr;
      logic       win_shift;
      logic [1:0] win_idx;
      logic       reduce_step;
      logic       mac_mul;
      logic       mac_acc;
      logic [4:0] term;
      logic       set_degen;
      logic       sqrt_init;
      logic       sqrt_step;
      logic       norm_step;
      logic       cordic_init;
      logic       cordic_step;
      logic [4:0] cordic_idx;
      logic       fin_angle;
      logic       fin_round;
      logic       out_write;
   } das_cmd_type;

   typedef struct packed {
      logic reduce_done;
      logic degen;
      logic norm_done;
   } das_status_type;

   function automatic logic [21:0] das_atan(input logic [4:0] idx);
      logic [21:0] r;
      begin
         case (idx)
            5'd0:    r = 22'd2949120;
            5'd1:    r = 22'd1740967;
            5'd2:    r = 22'd919879;
            5'd3:    r = 22'd466945;
            5'd4:    r = 22'd234379;
            5'd5:    r = 22'd117304;
            5'd6:    r = 22'd58666;
            5'd7:    r = 22'd29335;
            5'd8:    r = 22'd14668;
            5'd9:    r = 22'd7334;
            5'd10:   r = 22'd3667;
            5'd11:   r = 22'd1833;
            5'd12:   r = 22'd917;
            5'd13:   r = 22'd458;
            5'd14:   r = 22'd229;
            5'd15:   r = 22'd115;
            5'd16:   r = 22'd57;
            5'd17:   r = 22'd29;
            5'd18:   r = 22'd14;
            5'd19:   r = 22'd7;
            5'd20:   r = 22'd4;
            5'd21:   r = 22'd2;
            5'd22:   r = 22'd1;
            default: r = 22'd0;
         endcase
         return r;
      end
   endfunction

endpackage

>>> hw/rtl/das_req_if.sv
`timescale 1ns / 1ps
interface das_req_if #(
   parameter int COORD_BITS = 25
) ();
   logic                         valid;
   logic                         ready;
   logic                         first_atom;
   logic signed [COORD_BITS-1:0] coord_x;
   logic signed [COORD_BITS-1:0] coord_y;
   logic signed [COORD_BITS-1:0] coord_z;

   modport source (output valid, first_atom, coord_x, coord_y, coord_z, input ready);
   modport sink (input valid, first_atom, coord_x, coord_y, coord_z, output ready);
endinterface

>>> hw/rtl/das_rsp_if.sv
`timescale 1ns / 1ps
interface das_rsp_if ();
   logic               valid;
   logic               ready;
   logic signed [15:0] twist_angle;
   logic               degenerate;

   modport source (output valid, twist_angle, degenerate, input ready);
   modport sink (input valid, twist_angle, degenerate, output ready);
endinterface

>>> hw/rtl/das_csr_if.sv
`timescale 1ns / 1ps
interface das_csr_if ();
   logic       valid;
   logic       ready;
   logic [3:0] window_stride;

   modport source (output valid, window_stride, input ready);
   modport sink (input valid, window_stride, output ready);
endinterface

>>> hw/rtl/das_datapath.sv
`timescale 1ns / 1ps
module das_datapath
   import das_pkg::*;
#(
   parameter int COORD_BITS = 25
) (
   input  logic                         clock,
   input  das_cmd_type                  cmd,
   output das_status_type               status,
   input  logic signed [COORD_BITS-1:0] coord_x,
   input  logic signed [COORD_BITS-1:0] coord_y,
   input  logic signed [COORD_BITS-1:0] coord_z,
   output logic signed [15:0]           twist_angle,
   output logic                         degenerate
);

   localparam int DIFF_W  = COORD_BITS + 1;
   localparam int OP_W    = 32;
   localparam int PROD_W  = 64;
   localparam int ACC_W   = 66;
   localparam int X_W     = 62;
   localparam int YR_W    = 48;
   localparam int N_W     = 30;
   localparam int SQ_W    = 34;
   localparam int CORD_W  = 35;
   localparam int Z_W     = 32;
   localparam int ZF_W    = 24;
   localparam int QUARTER = 90 * 65536;
   localparam int HALF    = 180 * 65536;

   typedef enum logic [3:0] {
      DST_NONE, DST_U1X, DST_U1Y, DST_U1Z, DST_U2X, DST_U2Y, DST_U2Z,
      DST_X, DST_YR, DST_N, DST_AY
   } das_dst_type;

   logic signed [COORD_BITS-1:0] win_ff [3][3];
   logic signed [COORD_BITS-1:0] new_atom [3];
   logic signed [COORD_BITS-1:0] pt [4][3];
   logic signed [DIFF_W-1:0]     diff [3][3];
   logic [DIFF_W-1:0]            diff_mag [3][3];
   logic [DIFF_W-1:0]            mag_ff [3][3];
   logic                         sgn_ff [3][3];
   logic                         big [3];
   logic signed [DIR_BITS-1:0]   dv [3][3];

   logic signed [OP_W-1:0]   u1_ff [3];
   logic signed [OP_W-1:0]   u2_ff [3];
   logic signed [X_W-1:0]    x_ff;
   logic signed [YR_W-1:0]   yr_ff;
   logic [N_W-1:0]           n_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [ACC_W-1:0]  addend;

   logic signed [OP_W-1:0] op_a;
   logic signed [OP_W-1:0] op_b;
   logic                   t_first;
   logic                   t_neg;
   logic                   t_shift;
   das_dst_type            t_dst;

   logic [YR_W-1:0] yr_mag;
   logic [X_W-1:0]  x_mag;

   logic [SQ_W-1:0] rem_ff;
   logic [SQ_W-1:0] root_ff;
   logic [SQ_W-1:0] bit_ff;
   logic [SQ_W-1:0] trial;

   logic [63:0] ax_ff;
   logic [63:0] ay_ff;

   logic signed [CORD_W-1:0] cx_ff;
   logic signed [CORD_W-1:0] cy_ff;
   logic signed [Z_W-1:0]    cz_ff;
   logic signed [CORD_W-1:0] xs;
   logic signed [CORD_W-1:0] ys;
   logic signed [Z_W-1:0]    step_ang;

   logic signed [Z_W-1:0] zc;
   logic [ZF_W-1:0]       zf_ff;
   logic [31:0]           scaled;
   logic [15:0]           h;

   logic signed [15:0] res_angle_ff;
   logic               res_deg_ff;
   logic signed [15:0] angle_out_ff;
   logic               deg_out_ff;

   assign new_atom[0] = coord_x;
   assign new_atom[1] = coord_y;
   assign new_atom[2] = coord_z;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         pt[0][a] = win_ff[0][a];
         pt[1][a] = win_ff[1][a];
         pt[2][a] = win_ff[2][a];
         pt[3][a] = new_atom[a];
      end
      for (int v = 0; v < 3; v++) begin
         for (int a = 0; a < 3; a++) begin
            diff[v][a] = DIFF_W'(pt[v+1][a]) - DIFF_W'(pt[v][a]);
            diff_mag[v][a] = diff[v][a][DIFF_W-1] ? DIFF_W'(-diff[v][a])
                                                  : DIFF_W'(diff[v][a]);
         end
      end
   end

   always_comb begin
      for (int v = 0; v < 3; v++) begin
         big[v] = (mag_ff[v][0] > DIFF_W'(DIR_MAX)) || (mag_ff[v][1] > DIFF_W'(DIR_MAX)) ||
                  (mag_ff[v][2] > DIFF_W'(DIR_MAX));
         for (int a = 0; a < 3; a++) begin
            dv[v][a] = sgn_ff[v][a] ? -$signed({1'b0, mag_ff[v][a][DIR_BITS-2:0]})
                                    : $signed({1'b0, mag_ff[v][a][DIR_BITS-2:0]});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.win_wr) begin
         for (int a = 0; a < 3; a++) begin
            win_ff[cmd.win_idx][a] <= new_atom[a];
         end
      end else if (cmd.win_shift) begin
         for (int a = 0; a < 3; a++) begin
            win_ff[0][a] <= win_ff[1][a];
            win_ff[1][a] <= win_ff[2][a];
            win_ff[2][a] <= new_atom[a];
         end
      end
      if (cmd.load) begin
         for (int v = 0; v < 3; v++) begin
            for (int a = 0; a < 3; a++) begin
               mag_ff[v][a] <= diff_mag[v][a];
               sgn_ff[v][a] <= diff[v][a][DIFF_W-1];
            end
         end
      end else if (cmd.reduce_step) begin
         for (int v = 0; v < 3; v++) begin
            if (big[v]) begin
               for (int a = 0; a < 3; a++) begin
                  mag_ff[v][a] <= mag_ff[v][a] >> 1;
               end
            end
         end
      end
   end

   assign status.reduce_done = !(big[0] || big[1] || big[2]);
   assign status.degen = ((u1_ff[0] == '0) && (u1_ff[1] == '0) && (u1_ff[2] == '0)) ||
                         ((u2_ff[0] == '0) && (u2_ff[1] == '0) && (u2_ff[2] == '0));
   assign status.norm_done = (ax_ff[63:30] == '0) && (ay_ff[63:30] == '0);

   assign yr_mag = yr_ff[YR_W-1] ? YR_W'(-yr_ff) : YR_W'(yr_ff);
   assign x_mag  = x_ff[X_W-1] ? X_W'(-x_ff) : X_W'(x_ff);

   always_comb begin
      op_a    = '0;
      op_b    = '0;
      t_first = 1'b0;
      t_neg   = 1'b0;
      t_shift = 1'b0;
      t_dst   = DST_NONE;
      case (cmd.term)
         5'd0: begin
            op_a = OP_W'(dv[0][1]); op_b = OP_W'(dv[1][2]); t_first = 1'b1;
         end
         5'd1: begin
            op_a = OP_W'(dv[0][2]); op_b = OP_W'(dv[1][1]); t_neg = 1'b1; t_dst = DST_U1X;
         end
         5'd2: begin
            op_a = OP_W'(dv[0][2]); op_b = OP_W'(dv[1][0]); t_first = 1'b1;
         end
         5'd3: begin
            op_a = OP_W'(dv[0][0]); op_b = OP_W'(dv[1][2]); t_neg = 1'b1; t_dst = DST_U1Y;
         end
         5'd4: begin
            op_a = OP_W'(dv[0][0]); op_b = OP_W'(dv[1][1]); t_first = 1'b1;
         end
         5'd5: begin
            op_a = OP_W'(dv[0][1]); op_b = OP_W'(dv[1][0]); t_neg = 1'b1; t_dst = DST_U1Z;
         end
         5'd6: begin
            op_a = OP_W'(dv[1][1]); op_b = OP_W'(dv[2][2]); t_first = 1'b1;
         end
         5'd7: begin
            op_a = OP_W'(dv[1][2]); op_b = OP_W'(dv[2][1]); t_neg = 1'b1; t_dst = DST_U2X;
         end
         5'd8: begin
            op_a = OP_W'(dv[1][2]); op_b = OP_W'(dv[2][0]); t_first = 1'b1;
         end
         5'd9: begin
            op_a = OP_W'(dv[1][0]); op_b = OP_W'(dv[2][2]); t_neg = 1'b1; t_dst = DST_U2Y;
         end
         5'd10: begin
            op_a = OP_W'(dv[1][0]); op_b = OP_W'(dv[2][1]); t_first = 1'b1;
         end
         5'd11: begin
            op_a = OP_W'(dv[1][1]); op_b = OP_W'(dv[2][0]); t_neg = 1'b1; t_dst = DST_U2Z;
         end
         5'd12: begin
            op_a = u1_ff[0]; op_b = u2_ff[0]; t_first = 1'b1;
         end
         5'd13: begin
            op_a = u1_ff[1]; op_b = u2_ff[1];
         end
         5'd14: begin
            op_a = u1_ff[2]; op_b = u2_ff[2]; t_dst = DST_X;
         end
         5'd15: begin
            op_a = OP_W'(dv[0][0]); op_b = u2_ff[0]; t_first = 1'b1;
         end
         5'd16: begin
            op_a = OP_W'(dv[0][1]); op_b = u2_ff[1];
         end
         5'd17: begin
            op_a = OP_W'(dv[0][2]); op_b = u2_ff[2]; t_dst = DST_YR;
         end
         5'd18: begin
            op_a = OP_W'(dv[1][0]); op_b = OP_W'(dv[1][0]); t_first = 1'b1;
         end
         5'd19: begin
            op_a = OP_W'(dv[1][1]); op_b = OP_W'(dv[1][1]);
         end
         5'd20: begin
            op_a = OP_W'(dv[1][2]); op_b = OP_W'(dv[1][2]); t_dst = DST_N;
         end
         5'd21: begin
            op_a = $signed({14'd0, root_ff[17:0]});
            op_b = $signed({9'd0, yr_mag[46:24]});
            t_first = 1'b1; t_shift = 1'b1;
         end
         5'd22: begin
            op_a = $signed({14'd0, root_ff[17:0]});
            op_b = $signed({8'd0, yr_mag[23:0]});
            t_dst = DST_AY;
         end
         default: begin
            op_a = '0;
         end
      endcase
   end

   always_comb begin
      addend = t_shift ? (ACC_W'(prod_ff) <<< 24) : ACC_W'(prod_ff);
      acc_in = (t_first ? ACC_W'(0) : acc_ff) + (t_neg ? -addend : addend);
   end

   always_ff @(posedge clock) begin
      if (cmd.mac_mul) begin
         prod_ff <= op_a * op_b;
      end
      if (cmd.mac_acc) begin
         acc_ff <= acc_in;
         case (t_dst)
            DST_U1X: u1_ff[0] <= acc_in[OP_W-1:0];
            DST_U1Y: u1_ff[1] <= acc_in[OP_W-1:0];
            DST_U1Z: u1_ff[2] <= acc_in[OP_W-1:0];
            DST_U2X: u2_ff[0] <= acc_in[OP_W-1:0];
            DST_U2Y: u2_ff[1] <= acc_in[OP_W-1:0];
            DST_U2Z: u2_ff[2] <= acc_in[OP_W-1:0];
            DST_X:   x_ff <= acc_in[X_W-1:0];
            DST_YR:  yr_ff <= acc_in[YR_W-1:0];
            DST_N:   n_ff <= acc_in[N_W-1:0];
            DST_AY: begin
               ay_ff <= acc_in[63:0];
               ax_ff <= {x_mag, 2'b00};
            end
            default: begin
            end
         endcase
      end else if (cmd.norm_step) begin
         ax_ff <= ax_ff >> 1;
         ay_ff <= ay_ff >> 1;
      end
   end

   assign trial = root_ff + bit_ff;

   always_ff @(posedge clock) begin
      if (cmd.sqrt_init) begin
         rem_ff  <= {n_ff, 4'b0000};
         root_ff <= '0;
         bit_ff  <= SQ_W'(1) << 32;
      end else if (cmd.sqrt_step) begin
         if (rem_ff >= trial) begin
            rem_ff  <= rem_ff - trial;
            root_ff <= (root_ff >> 1) + bit_ff;
         end else begin
            root_ff <= root_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   assign xs       = cx_ff >>> cmd.cordic_idx;
   assign ys       = cy_ff >>> cmd.cordic_idx;
   assign step_ang = $signed({10'd0, das_atan(cmd.cordic_idx)});

   always_ff @(posedge clock) begin
      if (cmd.cordic_init) begin
         cx_ff <= $signed({5'd0, ax_ff[29:0]});
         cy_ff <= $signed({5'd0, ay_ff[29:0]});
         cz_ff <= '0;
      end else if (cmd.cordic_step) begin
         if (cy_ff > 0) begin
            cx_ff <= cx_ff + ys;
            cy_ff <= cy_ff - xs;
            cz_ff <= cz_ff + step_ang;
         end else begin
            cx_ff <= cx_ff - ys;
            cy_ff <= cy_ff + xs;
            cz_ff <= cz_ff - step_ang;
         end
      end
   end

   always_comb begin
      if (cz_ff < 0) begin
         zc = '0;
      end else if (cz_ff > Z_W'(QUARTER)) begin
         zc = Z_W'(QUARTER);
      end else begin
         zc = cz_ff;
      end
      scaled = (32'(zf_ff) << 6) + (32'(zf_ff) << 5) + (32'(zf_ff) << 2) + 32'd32768;
      h      = scaled[31:16];
   end

   always_ff @(posedge clock) begin
      if (cmd.fin_angle) begin
         zf_ff <= x_ff[X_W-1] ? ZF_W'(Z_W'(HALF) - zc) : ZF_W'(zc);
      end
      if (cmd.set_degen) begin
         res_angle_ff <= '0;
         res_deg_ff   <= 1'b1;
      end else if (cmd.fin_round) begin
         res_angle_ff <= yr_ff[YR_W-1] ? -$signed(h) : $signed(h);
         res_deg_ff   <= 1'b0;
      end
      if (cmd.out_write) begin
         angle_out_ff <= res_angle_ff;
         deg_out_ff   <= res_deg_ff;
      end
   end

   assign twist_angle = angle_out_ff;
   assign degenerate  = deg_out_ff;

endmodule

>>> hw/rtl/das_control.sv
`timescale 1ns / 1ps
module das_control
   import das_pkg::*;
#(
   parameter int ANGLE_ITERATIONS = 16
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  logic           first_atom,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  logic           csr_valid,
   output logic           csr_ready,
   input  logic [3:0]     csr_stride,
   input  das_status_type status,
   output das_cmd_type    cmd
);

   localparam int CNT_MAX = (ANGLE_ITERATIONS > SQRT_STEPS) ? ANGLE_ITERATIONS : SQRT_STEPS;
   localparam int CNT_W   = $clog2(CNT_MAX + 1);

   das_state_type    state_ff, state_in;
   logic [4:0]       term_ff, term_in;
   logic [CNT_W-1:0] iter_ff, iter_in;
   logic [1:0]       filled_ff, filled_in;
   logic [3:0]       phase_ff, phase_in;
   logic [3:0]       stride_ff;
   logic             rsp_valid_ff;

   logic       accept;
   logic [1:0] filled_eff;
   logic [3:0] phase_eff;
   logic [3:0] stride_eff;
   logic [4:0] phase_inc;
   logic [3:0] phase_next;

   assign req_ready  = (state_ff == ST_IDLE);
   assign accept     = req_valid && req_ready;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign filled_eff = first_atom ? 2'd0 : filled_ff;
   assign phase_eff  = first_atom ? 4'd0 : phase_ff;
   assign stride_eff = (stride_ff == 4'd0) ? 4'd1 : stride_ff;
   assign phase_inc  = {1'b0, phase_eff} + 5'd1;
   assign phase_next = (phase_inc >= {1'b0, stride_eff}) ? 4'd0 : phase_inc[3:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         term_ff      <= '0;
         iter_ff      <= '0;
         filled_ff    <= '0;
         phase_ff     <= '0;
         stride_ff    <= 4'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         term_ff   <= term_in;
         iter_ff   <= iter_in;
         filled_ff <= filled_in;
         phase_ff  <= phase_in;
         if (csr_valid) begin
            stride_ff <= csr_stride;
         end
         if (cmd.out_write) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      state_in        = state_ff;
      term_in         = term_ff;
      iter_in         = iter_ff;
      filled_in       = filled_ff;
      phase_in        = phase_ff;
      cmd             = '0;
      cmd.term        = term_ff;
      cmd.cordic_idx  = iter_ff[4:0];
      cmd.win_idx     = filled_eff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (filled_eff == 2'd3) begin
                  cmd.win_shift = 1'b1;
                  filled_in     = filled_eff;
                  phase_in      = phase_next;
                  if (phase_eff == 4'd0) begin
                     cmd.load = 1'b1;
                     state_in = ST_REDUCE;
                  end
               end else begin
                  cmd.win_wr = 1'b1;
                  filled_in  = filled_eff + 2'd1;
                  phase_in   = phase_eff;
               end
            end
         end
         ST_REDUCE: begin
            if (status.reduce_done) begin
               term_in  = '0;
               state_in = ST_MAC_MUL;
            end else begin
               cmd.reduce_step = 1'b1;
            end
         end
         ST_MAC_MUL: begin
            cmd.mac_mul = 1'b1;
            state_in    = ST_MAC_ACC;
         end
         ST_MAC_ACC: begin
            cmd.mac_acc = 1'b1;
            if (term_ff == TERM_XYZ_LAST) begin
               state_in = ST_CHECK;
            end else if (term_ff == TERM_AY_LAST) begin
               state_in = ST_NORM;
            end else begin
               term_in  = term_ff + 5'd1;
               state_in = ST_MAC_MUL;
            end
         end
         ST_CHECK: begin
            if (status.degen) begin
               cmd.set_degen = 1'b1;
               state_in      = ST_WRITE;
            end else begin
               cmd.sqrt_init = 1'b1;
               iter_in       = '0;
               state_in      = ST_SQRT;
            end
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (iter_ff == CNT_W'(SQRT_STEPS - 1)) begin
               term_in  = TERM_AY_FIRST;
               state_in = ST_MAC_MUL;
            end else begin
               iter_in = iter_ff + CNT_W'(1);
            end
         end
         ST_NORM: begin
            if (status.norm_done) begin
               cmd.cordic_init = 1'b1;
               iter_in         = '0;
               state_in        = ST_CORDIC;
            end else begin
               cmd.norm_step = 1'b1;
            end
         end
         ST_CORDIC: begin
            cmd.cordic_step = 1'b1;
            if (iter_ff == CNT_W'(ANGLE_ITERATIONS - 1)) begin
               state_in = ST_FIN_ANGLE;
            end else begin
               iter_in = iter_ff + CNT_W'(1);
            end
         end
         ST_FIN_ANGLE: begin
            cmd.fin_angle = 1'b1;
            state_in      = ST_FIN_ROUND;
         end
         ST_FIN_ROUND: begin
            cmd.fin_round = 1'b1;
            state_in      = ST_WRITE;
         end
         ST_WRITE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_write = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> hw/rtl/dihedral_angle_stream.sv
`timescale 1ns / 1ps
// Channel  Dir   Transfer when        Payload
// req_bus  in    valid && ready       first_atom, coord_x, coord_y, coord_z
// rsp_bus  out   valid && ready       twist_angle, degenerate
// csr_bus  in    valid && ready       window_stride
//
// An atom that only fills or slides the window leaves the block idle, ready for the next atom.
// An atom that closes a window holds the input while the block reduces the differences, forms
// the cross and dot products, takes the square root, normalises, runs the CORDIC and rounds;
// a degenerate window goes from the products straight to the result write.
// Synchronous active-high reset clears control state and sets the stride to one.
// A pending result holds in the output register; the next atom is taken meanwhile.
module dihedral_angle_stream
   import das_pkg::*;
#(
   parameter int ANGLE_ITERATIONS = 16,
   parameter int COORD_BITS       = 25
) (
   input logic       clock,
   input logic       reset,
   das_req_if.sink   req_bus,
   das_rsp_if.source rsp_bus,
   das_csr_if.sink   csr_bus
);

   das_cmd_type    cmd;
   das_status_type status;

   das_control #(
      .ANGLE_ITERATIONS(ANGLE_ITERATIONS)
   ) u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .first_atom(req_bus.first_atom),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .csr_valid (csr_bus.valid),
      .csr_ready (csr_bus.ready),
      .csr_stride(csr_bus.window_stride),
      .status    (status),
      .cmd       (cmd)
   );

   das_datapath #(
      .COORD_BITS(COORD_BITS)
   ) u_datapath (
      .clock      (clock),
      .cmd        (cmd),
      .status     (status),
      .coord_x    (req_bus.coord_x),
      .coord_y    (req_bus.coord_y),
      .coord_z    (req_bus.coord_z),
      .twist_angle(rsp_bus.twist_angle),
      .degenerate (rsp_bus.degenerate)
   );

endmodule

>>> tb/sv/dihedral_angle_stream_tb.sv
`timescale 1ns / 1ps
module dihedral_angle_stream_tb
   import das_pkg::*;
();

   localparam int CHAIN_BITS = 25;
   localparam int WATCHDOG   = 20000;

   typedef struct {
      logic                         first_atom;
      logic signed [CHAIN_BITS-1:0] x;
      logic signed [CHAIN_BITS-1:0] y;
      logic signed [CHAIN_BITS-1:0] z;
      int                           stride;   // -1: no register write before this atom
      bit                           drain;    // wait for all angles before sending
   } atom_type;

   typedef struct {
      logic signed [15:0] angle;
      logic               degen;
   } angle_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   das_req_if #(.COORD_BITS(CHAIN_BITS)) req_bus ();
   das_rsp_if rsp_bus ();
   das_csr_if csr_bus ();

   dihedral_angle_stream #(.ANGLE_ITERATIONS(16), .COORD_BITS(CHAIN_BITS)) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source),
      .csr_bus (csr_bus.sink)
   );

   always #5 clock = ~clock;

   atom_type  atom_queue[$];
   angle_type angle_queue[$];

   longint     win_x[3], win_y[3], win_z[3];
   int         filled;
   int         phase;
   logic [3:0] stride_reg;

   int  mismatches;
   int  idle_cycles;
   bit  stim_done;
   bit  timed_out;

   function automatic longint mag(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic void shrink(ref longint v[3]);
      longint m;
      int     s;
      m = 0;
      s = 0;
      for (int i = 0; i < 3; i++) if (mag(v[i]) > m) m = mag(v[i]);
      while ((m >>> s) > DIR_MAX) s++;
      for (int i = 0; i < 3; i++) v[i] = v[i] < 0 ? -(mag(v[i]) >>> s) : (mag(v[i]) >>> s);
   endfunction

   function automatic longint root_floor(longint n);
      longint r;
      r = 0;
      for (longint b = 64'sd1 <<< 31; b > 0; b = b >>> 1)
         if ((r + b) * (r + b) <= n) r += b;
      return r;
   endfunction

   function automatic angle_type torsion_of(longint p[4][3]);
      longint    d1[3], d2[3], d3[3], u1[3], u2[3];
      longint    dx, dy, ax, ay, cx, cy, ang, xs, ys, h;
      int        s;
      angle_type r;
      for (int i = 0; i < 3; i++) begin
         d1[i] = p[1][i] - p[0][i];
         d2[i] = p[2][i] - p[1][i];
         d3[i] = p[3][i] - p[2][i];
      end
      shrink(d1);
      shrink(d2);
      shrink(d3);
      u1[0] = d1[1]*d2[2] - d1[2]*d2[1];
      u1[1] = d1[2]*d2[0] - d1[0]*d2[2];
      u1[2] = d1[0]*d2[1] - d1[1]*d2[0];
      u2[0] = d2[1]*d3[2] - d2[2]*d3[1];
      u2[1] = d2[2]*d3[0] - d2[0]*d3[2];
      u2[2] = d2[0]*d3[1] - d2[1]*d3[0];
      if ((u1[0] == 0 && u1[1] == 0 && u1[2] == 0) ||
          (u2[0] == 0 && u2[1] == 0 && u2[2] == 0)) begin
         r.angle = '0;
         r.degen = 1'b1;
         return r;
      end
      dx = u1[0]*u2[0] + u1[1]*u2[1] + u1[2]*u2[2];
      dy = d1[0]*u2[0] + d1[1]*u2[1] + d1[2]*u2[2];
      ax = mag(dx) * 4;
      ay = root_floor((d2[0]*d2[0] + d2[1]*d2[1] + d2[2]*d2[2]) * 16) * mag(dy);
      s = 0;
      while ((ax >>> s) >= 64'sd1073741824 || (ay >>> s) >= 64'sd1073741824) s++;
      cx = ax >>> s;
      cy = ay >>> s;
      ang = 0;
      for (int i = 0; i < 16; i++) begin
         xs = cx >>> i;
         ys = cy >>> i;
         if (cy > 0) begin
            cx += ys; cy -= xs; ang += longint'(das_atan(5'(i)));
         end else begin
            cx -= ys; cy += xs; ang -= longint'(das_atan(5'(i)));
         end
      end
      if (ang < 0) ang = 0;
      if (ang > 90 * 65536) ang = 90 * 65536;
      if (dx < 0) ang = 180 * 65536 - ang;
      h = (ang * 100 + 32768) >>> 16;
      if (dy < 0) h = -h;
      r.angle = 16'(h);
      r.degen = 1'b0;
      return r;
   endfunction

   function automatic void predict_atom(atom_type a);
      longint p[4][3];
      int     st;
      st = stride_reg == 0 ? 1 : int'(stride_reg);
      if (a.first_atom) begin
         filled = 0;
         phase = 0;
      end
      if (filled >= 3) begin
         if (phase == 0) begin
            for (int i = 0; i < 3; i++) begin
               p[i][0] = win_x[i]; p[i][1] = win_y[i]; p[i][2] = win_z[i];
            end
            p[3][0] = a.x; p[3][1] = a.y; p[3][2] = a.z;
            angle_queue.insert(angle_queue.size(), torsion_of(p));
         end
         phase = (phase + 1 >= st) ? 0 : (phase + 1) & 15;
         win_x[0] = win_x[1]; win_x[1] = win_x[2]; win_x[2] = a.x;
         win_y[0] = win_y[1]; win_y[1] = win_y[2]; win_y[2] = a.y;
         win_z[0] = win_z[1]; win_z[1] = win_z[2]; win_z[2] = a.z;
      end else begin
         win_x[filled] = a.x; win_y[filled] = a.y; win_z[filled] = a.z;
         filled++;
      end
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic signed [CHAIN_BITS-1:0] rand_coord(int mode);
      case (mode)
         0: return CHAIN_BITS'($signed($urandom_range(0, 19999998)) - 9999999);
         1: return CHAIN_BITS'($signed($urandom_range(0, 8000)) - 4000);
         2: return CHAIN_BITS'($urandom);
         default: return CHAIN_BITS'($signed($urandom_range(0, 40)) - 20);
      endcase
   endfunction

   function automatic atom_type make_atom(logic f, longint x, longint y, longint z);
      atom_type a;
      a.first_atom = f;
      a.x = CHAIN_BITS'(x);
      a.y = CHAIN_BITS'(y);
      a.z = CHAIN_BITS'(z);
      a.stride = -1;
      a.drain = 1'b0;
      return a;
   endfunction

   function automatic void queue_atom(atom_type a);
      atom_queue.insert(atom_queue.size(), a);
   endfunction

   initial begin
      atom_type a;
      int       mode, len, strides[6];
      strides = '{1, 15, 0, 2, 3, 7};
      // reasonable chain, then extremes, colinear, planar cases, then random chains with stride writes
      queue_atom(make_atom(0, 0, 0, 0));
      queue_atom(make_atom(0, 1500, 0, 0));
      queue_atom(make_atom(0, 2000, 1400, 0));
      queue_atom(make_atom(0, 3500, 1400, 800));
      queue_atom(make_atom(0, 3500, 1400, -800));
      queue_atom(make_atom(0, 4000, 0, 0));
      queue_atom(make_atom(0, 5500, 0, 0));
      queue_atom(make_atom(1, 9999999, 9999999, 9999999));
      queue_atom(make_atom(0, -9999999, -9999999, 9999999));
      queue_atom(make_atom(0, 9999999, -9999999, -9999999));
      queue_atom(make_atom(0, -9999999, 9999999, -9999999));
      queue_atom(make_atom(0, 1, 0, 0));
      queue_atom(make_atom(0, 1, 1, 0));
      queue_atom(make_atom(0, 0, 1, 0));
      queue_atom(make_atom(0, 0, 1, 1));
      queue_atom(make_atom(1, 0, 0, 0));
      queue_atom(make_atom(0, 0, 0, 0));
      queue_atom(make_atom(0, 0, 0, 0));
      queue_atom(make_atom(0, 0, 0, 0));
      queue_atom(make_atom(0, -16777216, 16777215, -16777216));
      queue_atom(make_atom(0, 16777215, -16777216, 16777215));
      queue_atom(make_atom(1, 0, 0, 0));
      queue_atom(make_atom(0, 1, 0, 0));
      queue_atom(make_atom(0, 1, 1, 0));
      queue_atom(make_atom(0, 2, 1, 0));
      for (int ph = 0; ph < 6; ph++) begin
         for (int c = 0; c < 15 + ph; c++) begin
            mode = $urandom_range(0, 9) < 6 ? 1 : $urandom_range(0, 3);
            len = $urandom_range(0, 9) == 0 ? $urandom_range(1, 3) : $urandom_range(4, 20);
            for (int k = 0; k < len; k++) begin
               a = make_atom(k == 0 ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 40) == 0),
                             0, 0, 0);
               a.x = rand_coord(mode);
               a.y = rand_coord(mode);
               a.z = rand_coord(mode);
               if (c == 0 && k == 0) begin
                  a.stride = strides[ph];
                  a.drain = 1'b1;
               end else if (c == 6 && k == 0) begin
                  a.drain = 1'b1;
               end
               queue_atom(a);
            end
         end
      end
   end

   // request driver
   int   req_gap;
   int   csr_wait;
   logic req_fire = 1'b0;
   logic csr_fire = 1'b0;

   always @(posedge clock) begin
      req_fire <= req_bus.valid && req_bus.ready;
      csr_fire <= csr_bus.valid && csr_bus.ready;
   end

   task automatic a_drive(atom_type a);
      req_bus.valid <= 1'b1;
      req_bus.first_atom <= a.first_atom;
      req_bus.coord_x <= a.x;
      req_bus.coord_y <= a.y;
      req_bus.coord_z <= a.z;
      req_gap <= gap_len();
      csr_wait <= 0;
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.first_atom <= 1'b0;
         req_bus.coord_x <= '0;
         req_bus.coord_y <= '0;
         req_bus.coord_z <= '0;
         csr_bus.valid <= 1'b0;
         csr_bus.window_stride <= '0;
         req_gap <= 0;
         csr_wait <= 0;
      end else if (csr_bus.valid) begin
         // drop the write once transferred
         if (csr_fire) csr_bus.valid <= 1'b0;
      end else if (req_bus.valid && !req_fire) begin
         // hold
      end else if (req_gap > 0) begin
         req_bus.valid <= 1'b0;
         req_gap <= req_gap - 1;
      end else if (atom_queue.size() == 0) begin
         req_bus.valid <= 1'b0;
         stim_done <= 1'b1;
      end else if ((atom_queue[0].drain || atom_queue[0].stride >= 0) &&
                   (angle_queue.size() != 0 || req_bus.valid || csr_wait < 200)) begin
         req_bus.valid <= 1'b0;
         csr_wait <= angle_queue.size() != 0 || req_bus.valid ? 0 : csr_wait + 1;
      end else if (atom_queue[0].stride >= 0) begin
         csr_bus.valid <= 1'b1;
         csr_bus.window_stride <= 4'(atom_queue[0].stride);
         atom_queue[0].stride = -1;
         csr_wait <= 0;
      end else begin
         a_drive(atom_queue.pop_front());
      end
   end

   int rsp_gap;
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_gap <= 0;
      end else if (rsp_gap > 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_gap <= rsp_gap - 1;
      end else begin
         rsp_bus.ready <= 1'b1;
         rsp_gap <= gap_len();
      end
   end

   // monitor and predictor
   always @(posedge clock) begin
      if (reset) begin
         filled = 0;
         phase = 0;
         stride_reg = 4'd1;
         idle_cycles <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            predict_atom(make_atom(req_bus.first_atom, req_bus.coord_x,
                                   req_bus.coord_y, req_bus.coord_z));
         if (csr_bus.valid && csr_bus.ready) stride_reg = csr_bus.window_stride;
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (angle_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected angle %0d degenerate %0b",
                           rsp_bus.twist_angle, rsp_bus.degenerate);
            end else if (angle_queue[0].angle !== rsp_bus.twist_angle ||
                         angle_queue[0].degen !== rsp_bus.degenerate) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("angle mismatch: expected %0d/%0b, got %0d/%0b",
                           angle_queue[0].angle, angle_queue[0].degen,
                           rsp_bus.twist_angle, rsp_bus.degenerate);
               void'(angle_queue.pop_front());
            end else begin
               void'(angle_queue.pop_front());
            end
         end
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      mismatches = 0;
      stim_done = 1'b0;
      timed_out = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      while (!(stim_done && angle_queue.size() == 0) && !timed_out) begin
         @(posedge clock);
         if (idle_cycles > WATCHDOG) timed_out = 1'b1;
      end
      if (timed_out) begin
         $display("*** FAILED ***");
      end else begin
         repeat (300) @(posedge clock);
         if (mismatches == 0 && angle_queue.size() == 0) begin
            $display("*** PASSED ***");
         end else begin
            $display("*** FAILED ***");
         end
      end
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/das_pkg.sv
hw/rtl/das_req_if.sv
hw/rtl/das_rsp_if.sv
hw/rtl/das_csr_if.sv
hw/rtl/das_datapath.sv
hw/rtl/das_control.sv
hw/rtl/dihedral_angle_stream.sv
tb/sv/dihedral_angle_stream_tb.sv
